[sv/marker_length_frame_delimiter_assert.svh]
// Assertion macros for the frame delimiter checker.
// Include only from files that assert; no other dependencies.
`ifndef MARKER_LENGTH_FRAME_DELIMITER_ASSERT_SVH
`define MARKER_LENGTH_FRAME_DELIMITER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlfd assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlfd assertion failed");

`endif

[sv/mlfd_pkg.sv]
// Shared types and constants for the marker/length frame delimiter.
// No dependencies.
`default_nettype none

package mlfd_pkg;

  localparam int unsigned MAX_FRAME    = 4096;
  localparam int unsigned POS_W        = $clog2(MAX_FRAME + 1);
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned BYTE_POS_W   = 12;
  localparam int unsigned CUT_LEN_W    = 13;

  // frame positions holding the big-endian length word, and where it is taken
  localparam logic [POS_W-1:0] LEN_FIRST_POS   = POS_W'(3);
  localparam logic [POS_W-1:0] LEN_LAST_POS    = POS_W'(6);
  localparam logic [POS_W-1:0] LEN_CAPTURE_POS = POS_W'(7);

  localparam logic [7:0] MARKER_FIRST_RST  = 8'hff;
  localparam logic [7:0] MARKER_SECOND_RST = 8'h00;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_DONE     = 2'd1,
    EV_CUT      = 2'd2,
    EV_OVERFLOW = 2'd3
  } frame_event_t;

  typedef enum logic {
    CFG_MARKER_FIRST  = 1'b0,
    CFG_MARKER_SECOND = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       prev_byte;
    logic [LEN_W-1:0] len_cap;
    logic [LEN_W-1:0] exp_len;
  } frame_state_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic [BYTE_POS_W-1:0] byte_position;
    frame_event_t          frame_event;
    logic [CUT_LEN_W-1:0]  cut_length;
  } frame_result_t;

endpackage

`default_nettype wire

[sv/marker_length_frame_delimiter.sv]
// Marker/length frame delimiter, top level: input register, per-byte update, result register.
// Depends on mlfd_pkg and mlfd_next.
// One request per received byte, one result request per byte, in order. Each byte
// first lands in an input register. The framing update (mlfd_next) then runs on it
// against the frame state, and the result is written to the output register once
// that register is free or its result is being taken. A new byte is taken every cycle
// while out_ready stays high (one byte per cycle sustained, set by the single framing
// state update per cycle).
// While a result waits on out_ready, the input register still takes one more byte;
// with both registers full, in_ready drops until the result is taken. Frame bytes
// 3..6 carry a big-endian length captured at position 7; the frame closes on the
// byte at position equal to that length (event 1). The marker pair seen back to back
// inside a frame cuts it (event 2, cut length reported, byte at position 1). A
// byte that arrives with MAX_FRAME bytes already held drops the frame (event 3).
// The user must write the marker registers through cfg_* only while no request is in flight.
`default_nettype none

module marker_length_frame_delimiter
  import mlfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata,
  // received bytes
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data_byte,
  output logic [BYTE_POS_W-1:0] out_byte_position,
  output logic [1:0]            out_frame_event,
  output logic [CUT_LEN_W-1:0]  out_cut_length
);

  logic [7:0]    marker_first_r;
  logic [7:0]    marker_second_r;

  // input register stage
  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;

  // frame state
  frame_state_t  st_r;
  frame_state_t  st_nxt;

  // result register stage
  logic          out_valid_r;
  frame_result_t res_r;
  frame_result_t res_nxt;

  logic          advance;

  // the input byte moves to the result register when that register is free or being taken
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  mlfd_next u_next (
    .st            (st_r),
    .rx_byte       (s1_byte_r),
    .marker_first  (marker_first_r),
    .marker_second (marker_second_r),
    .st_nxt        (st_nxt),
    .res           (res_nxt)
  );

  // marker registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_first_r  <= MARKER_FIRST_RST;
      marker_second_r <= MARKER_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MARKER_FIRST:  marker_first_r  <= cfg_wdata;
        CFG_MARKER_SECOND: marker_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_byte     = res_r.data_byte;
  assign out_byte_position = res_r.byte_position;
  assign out_frame_event   = res_r.frame_event;
  assign out_cut_length    = res_r.cut_length;

endmodule

`default_nettype wire

[sv/mlfd_next.sv]
// Per-byte framing update: next frame state and the result for one byte.
// Depends on mlfd_pkg.
`default_nettype none

module mlfd_next
  import mlfd_pkg::*;
(
  input  frame_state_t  st,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    marker_first,
  input  logic [7:0]    marker_second,
  output frame_state_t  st_nxt,
  output frame_result_t res
);

  logic             hit;
  logic [POS_W-1:0] pos_e;
  logic [LEN_W-1:0] exp_e;
  logic [LEN_W-1:0] exp_c;
  logic [POS_W-1:0] pos_inc;

  assign hit   = (st.pos != '0) && (st.prev_byte == marker_first) &&
                 (rx_byte == marker_second);
  assign pos_e = hit ? POS_W'(1) : st.pos;
  assign exp_e = hit ? '0 : st.exp_len;
  assign exp_c = (pos_e == LEN_CAPTURE_POS) ? st.len_cap : exp_e;
  assign pos_inc = pos_e + POS_W'(1);

  always_comb begin
    st_nxt            = st;
    st_nxt.prev_byte  = rx_byte;
    res.data_byte     = rx_byte;
    res.byte_position = '0;
    res.frame_event   = hit ? EV_CUT : EV_NONE;
    res.cut_length    = hit ? CUT_LEN_W'(st.pos - POS_W'(1)) : '0;

    if (32'(pos_e) >= 32'(MAX_FRAME)) begin
      // store full: drop the frame and this byte
      res.frame_event = EV_OVERFLOW;
      st_nxt.pos      = '0;
      st_nxt.exp_len  = '0;
    end else begin
      if ((pos_e >= LEN_FIRST_POS) && (pos_e <= LEN_LAST_POS)) begin
        st_nxt.len_cap = {st.len_cap[LEN_W-9:0], rx_byte};
      end
      res.byte_position = BYTE_POS_W'(pos_e);
      if ((exp_c != '0) && (LEN_W'(pos_e) == exp_c)) begin
        res.frame_event = EV_DONE;
        st_nxt.pos      = '0;
        st_nxt.exp_len  = '0;
      end else begin
        st_nxt.pos      = pos_inc;
        st_nxt.exp_len  = exp_c;
      end
    end
  end

endmodule

`default_nettype wire

[sv/mlfd_checker.sv]
// Port-level checker for the frame delimiter, bound to the top level.
// Depends on mlfd_pkg and marker_length_frame_delimiter_assert.svh.
`default_nettype none

`include "marker_length_frame_delimiter_assert.svh"

module mlfd_checker
  import mlfd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [7:0]            out_data_byte,
  input logic [BYTE_POS_W-1:0] out_byte_position,
  input logic [1:0]            out_frame_event,
  input logic [CUT_LEN_W-1:0]  out_cut_length
);

  // a stalled result keeps its payload
  `MLFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data_byte) && $stable(out_byte_position) && $stable(out_cut_length))

  // a dropped frame reports position zero
  `MLFD_ASSERT_NOW(a_ovf_pos, clk, rst_n, out_valid && (out_frame_event == EV_OVERFLOW), out_byte_position == '0)

  // cut length only shows with a cut, and the cutting byte sits at position one
  `MLFD_ASSERT_NOW(a_cut_len, clk, rst_n, out_valid && (out_cut_length != '0), out_frame_event == EV_CUT)
  `MLFD_ASSERT_NOW(a_cut_pos, clk, rst_n, out_valid && (out_frame_event == EV_CUT), out_byte_position == BYTE_POS_W'(1))

  // a frame cannot close before its length word is taken
  `MLFD_ASSERT_NOW(a_done_pos, clk, rst_n, out_valid && (out_frame_event == EV_DONE), out_byte_position >= BYTE_POS_W'(LEN_CAPTURE_POS))

endmodule

bind marker_length_frame_delimiter mlfd_checker u_mlfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_data_byte     (out_data_byte),
  .out_byte_position (out_byte_position),
  .out_frame_event   (out_frame_event),
  .out_cut_length    (out_cut_length)
);

`default_nettype wire

[tb/frame_delimiter_checker.sv]
// Checker for the marker/length frame delimiter: watches the config port and both channels.
// Predicts one result per accepted byte and compares in order. Depends on mlfd_pkg.
`default_nettype none

module frame_delimiter_checker
  import mlfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [7:0]            cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_data_byte,
  input  logic [BYTE_POS_W-1:0] out_byte_position,
  input  logic [1:0]            out_frame_event,
  input  logic [CUT_LEN_W-1:0]  out_cut_length,
  output int                    mismatches,
  output int                    outstanding,
  output int                    frames_done,
  output int                    frames_cut,
  output int                    frames_dropped
);

  // marker registers as last written
  logic [7:0]    mk_first;
  logic [7:0]    mk_second;

  // framing state
  int unsigned   held;
  logic [7:0]    last_rx;
  logic [31:0]   len_shift;
  logic [31:0]   frame_len;

  frame_result_t byte_results[$];
  int            results_checked;

  initial begin
    mismatches     = 0;
    frames_done    = 0;
    frames_cut     = 0;
    frames_dropped = 0;
    outstanding    = 0;
  end

  function automatic frame_result_t predict_byte(input logic [7:0] rx);
    frame_result_t r;
    int unsigned   at;
    r.data_byte   = rx;
    r.frame_event = EV_NONE;
    r.cut_length  = '0;
    at            = 0;
    // marker pair inside a frame: restart with the first marker byte at position 0
    if (held != 0 && last_rx == mk_first && rx == mk_second) begin
      r.cut_length  = CUT_LEN_W'(held - 1);
      r.frame_event = EV_CUT;
      frame_len     = '0;
      held          = 1;
    end
    if (held >= MAX_FRAME) begin
      r.frame_event = EV_OVERFLOW;
      held          = 0;
      frame_len     = '0;
    end else begin
      if (held == int'(LEN_CAPTURE_POS)) frame_len = len_shift;
      if (held >= int'(LEN_FIRST_POS) && held <= int'(LEN_LAST_POS))
        len_shift = {len_shift[23:0], rx};
      at = held;
      held++;
      if (frame_len != 0 && {1'b0, frame_len} + 33'd1 == 33'(held)) begin
        r.frame_event = EV_DONE;
        frame_len     = '0;
        held          = 0;
      end
    end
    last_rx         = rx;
    r.byte_position = BYTE_POS_W'(at);
    return r;
  endfunction

  task automatic report(input string field, input int unsigned got, input int unsigned want);
    mismatches++;
    $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
             results_checked, field, got, want);
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      mk_first        = MARKER_FIRST_RST;
      mk_second       = MARKER_SECOND_RST;
      held            = 0;
      last_rx         = '0;
      len_shift       = '0;
      frame_len       = '0;
      results_checked = 0;
      byte_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MARKER_FIRST) mk_first = cfg_wdata;
        else mk_second = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (byte_results.size() == 0) begin
          report("result with no byte outstanding, data_byte", out_data_byte, 0);
        end else begin
          want = byte_results.pop_front();
          if (out_data_byte !== want.data_byte)
            report("data_byte", out_data_byte, want.data_byte);
          if (out_byte_position !== want.byte_position)
            report("byte_position", out_byte_position, want.byte_position);
          if (out_frame_event !== want.frame_event)
            report("frame_event", out_frame_event, want.frame_event);
          if (out_cut_length !== want.cut_length)
            report("cut_length", out_cut_length, want.cut_length);
          case (want.frame_event)
            EV_DONE:     frames_done++;
            EV_CUT:      frames_cut++;
            EV_OVERFLOW: frames_dropped++;
            default: ;
          endcase
        end
        results_checked++;
      end
      if (in_valid && in_ready) byte_results.push_back(predict_byte(in_rx_byte));
    end
    outstanding <= byte_results.size();
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// Top of the frame delimiter testbench: clock, reset, byte stimulus, marker writes, verdict.
// Depends on mlfd_pkg, marker_length_frame_delimiter and frame_delimiter_checker.
`default_nettype none

module tb;
  import mlfd_pkg::*;

  // cycles with no request moving on any port before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [7:0]            cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_data_byte;
  logic [BYTE_POS_W-1:0] out_byte_position;
  logic [1:0]            out_frame_event;
  logic [CUT_LEN_W-1:0]  out_cut_length;

  int mismatches;
  int outstanding;
  int frames_done;
  int frames_cut;
  int frames_dropped;

  // stimulus bookkeeping: markers as programmed, last byte accepted, byte count
  logic [7:0] mk_first;
  logic [7:0] mk_second;
  logic [7:0] last_sent;
  int         bytes_sent;
  int         settings_used;
  // no idling on either side while set
  logic       calm;

  marker_length_frame_delimiter uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_position (out_byte_position),
    .out_frame_event   (out_frame_event),
    .out_cut_length    (out_cut_length)
  );

  frame_delimiter_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_position (out_byte_position),
    .out_frame_event   (out_frame_event),
    .out_cut_length    (out_cut_length),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .frames_done       (frames_done),
    .frames_cut        (frames_cut),
    .frames_dropped    (frames_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random back-pressure, about 27 percent of the time, none while calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 27);
  end

  // Watchdog: any cycle where a request moves (or a register is written) rearms it.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog: no request moved for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, outstanding);
    $display("Regression FAIL");
    $finish;
  end

  // One byte request. An optional idle gap comes first (valid low), then valid
  // stays up with the byte held until the block takes it. Valid is only
  // lowered when a gap is taken, so back-to-back requests keep it high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 27) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_sent = b;
    bytes_sent++;
  endtask

  // Payload byte that never completes a marker pair with the byte before it,
  // so a well-formed frame is not cut by its own content.
  task automatic send_payload(input logic [7:0] b);
    if (last_sent == mk_first && b == mk_second) b = b ^ 8'h01;
    send_byte(b);
  endtask

  // Drop valid and wait until every byte has its result back, then let the two-stage
  // pipe settle. The first edge lets the count of owed results catch up with a
  // request taken on the edge just passed.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Program both marker bytes; only called with the block idle.
  task automatic set_markers(input logic [7:0] first_b, input logic [7:0] second_b);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MARKER_FIRST;
    cfg_wdata <= first_b;
    @(posedge clk);
    cfg_index <= CFG_MARKER_SECOND;
    cfg_wdata <= second_b;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mk_first  = first_b;
    mk_second = second_b;
    settings_used++;
  endtask

  // Random traffic for one marker setting. Mostly well-formed frames (marker
  // pair, one byte, big-endian length, payload up to the length), some cut
  // short; the rest is line noise and bursts of marker bytes.
  task automatic run_phase(input int quota);
    int          start;
    int          pick;
    int          frame_bytes;
    int          stop_at;
    int          k;
    logic [31:0] len_word;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        if (pick < 55) len_word = 32'($urandom_range(7, 24));
        else if (pick < 70) len_word = 32'($urandom_range(25, 120));
        else if (pick < 85) len_word = 32'($urandom_range(0, 6));  // never met
        else len_word = $urandom;
        frame_bytes = (len_word >= 7 && len_word <= 120) ? int'(len_word) + 1
                                                          : $urandom_range(8, 30);
        stop_at = ($urandom_range(99) < 15) ? $urandom_range(1, frame_bytes - 1)
                                            : frame_bytes;
        for (k = 0; k < stop_at; k++) begin
          if (k == 0) send_byte(mk_first);
          else if (k == 1) send_byte(mk_second);
          else if (k >= int'(LEN_FIRST_POS) && k <= int'(LEN_LAST_POS))
            send_byte(len_word[8*(int'(LEN_LAST_POS) - k) +: 8]);
          else send_payload(8'($urandom_range(255)));
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(2, 6)) send_byte($urandom_range(1) ? mk_first : mk_second);
      end
    end
  endtask

  initial begin
    logic [7:0] opening [0:21];
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_MARKER_FIRST;
    cfg_wdata  <= 8'h00;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    out_ready  <= 1'b0;
    calm       <= 1'b0;
    mk_first      = MARKER_FIRST_RST;
    mk_second     = MARKER_SECOND_RST;
    last_sent     = 8'h00;
    bytes_sent    = 0;
    settings_used = 1;  // reset markers count as the first setting
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under reset markers ff/00:
    //  - marker pair right at the start (cut of an empty frame), length 8,
    //    completes on position 8 with an ff as last byte
    //  - a 00 right after that completion: no cut at frame start
    //  - length 3, below seven, runs on until the marker pair cuts it
    //  - a second cut straight after, frame of two bytes
    opening = '{8'hff, 8'h00, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h08, 8'ha5, 8'hff,
                8'h00,
                8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h03, 8'h80, 8'h7f, 8'hff, 8'h00,
                8'hff, 8'h00};
    foreach (opening[i]) send_byte(opening[i]);
    run_phase(230);

    wait_idle();
    set_markers(8'h00, 8'hff);
    run_phase(250);

    // equal marker bytes, and a stretch with no idling on either side
    wait_idle();
    set_markers(8'h00, 8'h00);
    calm <= 1'b1;
    run_phase(250);
    calm <= 1'b0;

    wait_idle();
    set_markers(8'hff, 8'hff);
    run_phase(250);

    wait_idle();
    set_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(250);

    wait_idle();
    set_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(250);

    // back to the reset values through the port
    wait_idle();
    set_markers(MARKER_FIRST_RST, MARKER_SECOND_RST);
    run_phase(150);
    run_phase(100);

    wait_idle();
    $display("Sent %0d bytes under %0d marker settings.", bytes_sent, settings_used);
    $display("Seen %0d completed frames, %0d marker cuts, %0d overflow drops, %0d mismatches.",
             frames_done, frames_cut, frames_dropped, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
